@@ hdl/cfd_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the command frame deframer.
// No dependencies; compiled first.
`default_nettype none

package cfd_pkg;

   localparam int MAX_FRAME_BYTES = 258;
   localparam int HEADER_BYTES    = 10;
   localparam int COUNT_W         = 9;

   localparam logic [7:0]         SYNC_RESET  = 8'hAA;
   localparam logic [15:0]        CRC_POLY    = 16'h1021;
   localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_FRAME_BYTES);
   localparam logic [COUNT_W-1:0] HDR_COUNT   = COUNT_W'(HEADER_BYTES);

   // byte positions inside the header
   localparam logic [COUNT_W-1:0] POS_SYNC2   = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_TYPE    = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_BOX_HI  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_BOX_LO  = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] POS_STATUS  = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] POS_CRC_HI  = COUNT_W'(6);
   localparam logic [COUNT_W-1:0] POS_CRC_LO  = COUNT_W'(7);
   localparam logic [COUNT_W-1:0] POS_LEN_HI  = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] POS_LEN_LO  = COUNT_W'(9);

   // result queue
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = 2;
   localparam int RSPQ_CNT_W = 3;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_ACCEPT   = 2'd1,
      KIND_MISMATCH = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        last;
      logic [7:0]  payload_byte;
      logic [7:0]  msg_type;
      logic [15:0] msg_box;
      logic [7:0]  frame_status;
      logic [7:0]  payload_length;
      logic [15:0] crc_received;
   } rsp_word_type;

   // up to two result words produced by one accepted input word
   typedef struct packed {
      logic [1:0]   cnt;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   // CRC-16, poly 0x1021, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cfd_ifs.sv @@
// Handshake channel interfaces: request bytes, result words, sync register writes.
// No package dependency; kind is carried as a plain two-bit field.
`default_nettype none

interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        last;
   logic [7:0]  payload_byte;
   logic [7:0]  msg_type;
   logic [15:0] msg_box;
   logic [7:0]  frame_status;
   logic [7:0]  payload_length;
   logic [15:0] crc_received;
   modport source (output valid, output kind, output last, output payload_byte,
                   output msg_type, output msg_box, output frame_status,
                   output payload_length, output crc_received, input ready);
   modport sink   (input valid, input kind, input last, input payload_byte,
                   input msg_type, input msg_box, input frame_status,
                   input payload_length, input crc_received, output ready);
endinterface

interface cfd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] sync_byte;
   modport source (output valid, output sync_byte, input ready);
   modport sink   (input valid, input sync_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/command_frame_deframer_crc16_unit.sv @@
// Top level of the command frame deframer with CRC-16 check.
// Depends on cfd_pkg, cfd_ifs, cfd_core and cfd_rsp_queue.
//
//   channel  dir  word                                   accepted when
//   req_if   in   rx_byte                                valid && ready
//   rsp_if   out  kind, last, payload and header fields  valid && ready
//   csr_if   in   sync_byte                              valid && ready (ready tied high)
//
// One received byte is taken per cycle while there is room. It is parsed in the
// same cycle it is accepted and its zero, one or two result words land in a
// four-entry queue. req_if.ready holds while at least two queue entries are free,
// so a byte that yields two words (last payload byte plus frame end) always fits.
// Reset (synchronous, active high) empties the queue, leaves the parser idle and
// loads the sync register with 0xAA. Sink stalls only back up into req_if.ready.
`default_nettype none

module command_frame_deframer_crc16_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   cfd_req_if.sink    req_if,
   cfd_rsp_if.source  rsp_if,
   cfd_csr_if.sink    csr_if
);
   import cfd_pkg::*;

   logic [7:0]   sync_byte_ff;
   logic         req_fire;
   logic         room;
   logic         head_valid;
   push_type     push;
   rsp_word_type head;

   // sync register write port never stalls
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= SYNC_RESET;
      end else if (csr_if.valid) begin
         sync_byte_ff <= csr_if.sync_byte;
      end
   end

   assign req_if.ready = room;
   assign req_fire     = req_if.valid && room;

   cfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rx_byte   (req_if.rx_byte),
      .sync_byte (sync_byte_ff),
      .push      (push)
   );

   cfd_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (head_valid),
      .head_pop   (rsp_if.ready),
      .head       (head)
   );

   assign rsp_if.valid          = head_valid;
   assign rsp_if.kind           = head.kind;
   assign rsp_if.last           = head.last;
   assign rsp_if.payload_byte   = head.payload_byte;
   assign rsp_if.msg_type       = head.msg_type;
   assign rsp_if.msg_box        = head.msg_box;
   assign rsp_if.frame_status   = head.frame_status;
   assign rsp_if.payload_length = head.payload_length;
   assign rsp_if.crc_received   = head.crc_received;

   // parser produces nothing without an accepted byte
   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !req_fire |-> (push.cnt == 2'd0))
      else $error("result pushed without an accepted byte");

   // queue comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_if.valid)
      else $error("result valid right after reset");

   // overflow drop is always the only and final word of its byte
   a_overflow_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind == KIND_OVERFLOW) |-> rsp_if.last)
      else $error("overflow word without last");

   // a two-word push is always payload then frame end
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.cnt == 2'd2) |->
         (push.first.kind == KIND_PAYLOAD && !push.first.last && push.second.last &&
          (push.second.kind == KIND_ACCEPT || push.second.kind == KIND_MISMATCH)))
      else $error("bad two-word result order");

endmodule

`default_nettype wire

@@ hdl/cfd_core.sv @@
// Frame parser: header capture, running CRC, byte count and result word build.
// Depends on cfd_pkg.
`default_nettype none

module cfd_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_fire,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [7:0]         sync_byte,
   output cfd_pkg::push_type       push
);
   import cfd_pkg::*;

   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         type_ff, type_in;
   logic [15:0]        box_ff, box_in;
   logic [7:0]         status_ff, status_in;
   logic [15:0]        hcrc_ff, hcrc_in;
   logic [15:0]        len_ff, len_in;

   logic [COUNT_W-1:0] cnt_inc;
   logic [15:0]        crc_next;
   logic [15:0]        crc_first;
   rsp_word_type       end_word;
   rsp_word_type       pay_word;
   logic               frame_done;

   assign cnt_inc   = count_ff + COUNT_W'(1);
   assign crc_next  = crc16_byte(crc_ff, rx_byte);
   assign crc_first = crc16_byte(16'h0000, rx_byte);

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      type_in     = type_ff;
      box_in      = box_ff;
      status_in   = status_ff;
      hcrc_in     = hcrc_ff;
      len_in      = len_ff;
      push        = '0;
      end_word    = '0;
      pay_word    = '0;
      frame_done  = 1'b0;

      if (req_fire) begin
         if (!in_frame_ff) begin
            if (rx_byte == sync_byte) begin
               in_frame_in = 1'b1;
               count_in    = COUNT_W'(1);
               crc_in      = crc_first;
            end
         end else if (count_ff >= MAX_COUNT) begin
            // frame too long: drop it on this byte
            in_frame_in       = 1'b0;
            count_in          = '0;
            push.cnt          = 2'd1;
            push.first.kind   = KIND_OVERFLOW;
            push.first.last   = 1'b1;
         end else if (count_ff == POS_SYNC2 && rx_byte != sync_byte) begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            count_in = cnt_inc;
            case (count_ff)
               POS_TYPE:               type_in   = rx_byte;
               POS_BOX_HI, POS_BOX_LO: box_in    = {box_ff[7:0], rx_byte};
               POS_STATUS:             status_in = rx_byte;
               POS_CRC_HI, POS_CRC_LO: hcrc_in   = {hcrc_ff[7:0], rx_byte};
               POS_LEN_HI, POS_LEN_LO: len_in    = {len_ff[7:0], rx_byte};
               default:                ;
            endcase

            if (count_ff != POS_CRC_HI && count_ff != POS_CRC_LO) begin
               crc_in = crc_next;
            end

            if (count_ff >= HDR_COUNT) begin
               pay_word.kind         = KIND_PAYLOAD;
               pay_word.payload_byte = rx_byte;
               pay_word.last         = 1'b1;
               push.cnt              = 2'd1;
               push.first            = pay_word;
            end

            frame_done = (cnt_inc >= HDR_COUNT) &&
                         ({8'h00, cnt_inc} == (17'(HEADER_BYTES) + {1'b0, len_in}));

            if (frame_done) begin
               end_word.kind           = (crc_in == hcrc_in) ? KIND_ACCEPT : KIND_MISMATCH;
               end_word.last           = 1'b1;
               end_word.msg_type       = type_in;
               end_word.msg_box        = box_in;
               end_word.frame_status   = status_in;
               end_word.payload_length = len_in[7:0];
               end_word.crc_received   = hcrc_in;
               in_frame_in             = 1'b0;
               count_in                = '0;
               if (push.cnt == 2'd1) begin
                  push.first.last = 1'b0;
                  push.second     = end_word;
                  push.cnt        = 2'd2;
               end else begin
                  push.first = end_word;
                  push.cnt   = 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         crc_ff      <= '0;
         type_ff     <= '0;
         box_ff      <= '0;
         status_ff   <= '0;
         hcrc_ff     <= '0;
         len_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         type_ff     <= type_in;
         box_ff      <= box_in;
         status_ff   <= status_in;
         hcrc_ff     <= hcrc_in;
         len_ff      <= len_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cfd_rsp_queue.sv @@
// Four-entry result word queue; takes up to two words per cycle, hands out one.
// Depends on cfd_pkg.
`default_nettype none

module cfd_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfd_pkg::push_type   push,
   output logic                     room,
   output logic                     head_valid,
   input  wire logic                head_pop,
   output cfd_pkg::rsp_word_type    head
);
   import cfd_pkg::*;

   rsp_word_type          slot_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] fill_ff, fill_in;
   logic                  pop;
   logic [RSPQ_PTR_W-1:0] wr_ptr_nxt;

   assign head_valid = (fill_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign pop        = head_pop && head_valid;
   // two free entries needed, since one word may push two results
   assign room       = (fill_ff <= RSPQ_CNT_W'(RSPQ_DEPTH - 2));
   assign wr_ptr_nxt = wr_ptr_ff + RSPQ_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSPQ_PTR_W'(push.cnt);
      rd_ptr_in = rd_ptr_ff + RSPQ_PTR_W'(pop);
      fill_in   = fill_ff + RSPQ_CNT_W'(push.cnt) - RSPQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.cnt == 2'd2) begin
         slot_ff[wr_ptr_nxt] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/tb_command_frame_deframer_crc16_unit.sv @@
// Self-checking testbench for command_frame_deframer_crc16_unit: random framed byte
// streams with CRC-16 checks, compared word by word against an in-bench frame parser.
// Depends on cfd_pkg, cfd_ifs and the RTL top level.
`timescale 1ns / 100ps

module tb_command_frame_deframer_crc16_unit;
   import cfd_pkg::*;

   typedef logic [7:0] byte_list_type [$];

   localparam int SETTLE_CYCLES = 8;     // parse is same-cycle, queue is 4 deep
   localparam int HOLD_CYCLES   = 300;   // long sink hold-off
   localparam int LIMIT_CYCLES  = 5000;  // watchdog: cycles without any handshake
   localparam int PHASE_ITEMS   = 130;

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   cfd_req_if req_if ();
   cfd_rsp_if rsp_if ();
   cfd_csr_if csr_if ();

   command_frame_deframer_crc16_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // bytes waiting to be driven, and result words the parser model predicts
   byte_list_type byte_backlog;
   rsp_word_type  frame_results [$];

   int         error_count = 0;
   int         idle_cycles = 0;
   logic       req_taken   = 1'b0;
   logic [7:0] cur_sync    = SYNC_RESET;   // value last written by the stimulus

   // sink hold-off requests, served by the receiver process
   int hold_requests = 0;
   int hold_served   = 0;

   // ---------------- frame parser model ----------------
   logic [7:0]         sync_model = SYNC_RESET;
   logic               frm_open   = 1'b0;
   logic [COUNT_W-1:0] frm_count  = '0;
   logic [15:0]        frm_crc    = '0;
   logic [7:0]         hdr_type   = '0;
   logic [15:0]        hdr_box    = '0;
   logic [7:0]         hdr_status = '0;
   logic [15:0]        hdr_crc    = '0;
   logic [15:0]        hdr_len    = '0;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c  = {c[14:0], 1'b0};
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   // one accepted byte: zero, one or two predicted words
   task automatic deframe_byte(input logic [7:0] b);
      rsp_word_type       words [2];
      int                 n;
      logic [COUNT_W-1:0] pos;
      n        = 0;
      words[0] = '0;
      words[1] = '0;
      if (!frm_open) begin
         // hunting: only a sync byte opens a frame
         if (b == sync_model) begin
            frm_open  = 1'b1;
            frm_count = COUNT_W'(1);
            frm_crc   = crc16_step(16'h0000, b);
         end
         return;
      end
      if (frm_count >= MAX_COUNT) begin
         // buffer full and no end in sight: consume byte, drop frame
         frm_open       = 1'b0;
         frm_count      = '0;
         words[0].kind  = KIND_OVERFLOW;
         n              = 1;
      end else begin
         pos       = frm_count;
         frm_count = frm_count + COUNT_W'(1);
         if (pos == POS_SYNC2 && b != sync_model) begin
            frm_open  = 1'b0;
            frm_count = '0;
            return;
         end
         case (pos)
            POS_TYPE:               hdr_type   = b;
            POS_BOX_HI, POS_BOX_LO: hdr_box    = {hdr_box[7:0], b};
            POS_STATUS:             hdr_status = b;
            POS_CRC_HI, POS_CRC_LO: hdr_crc    = {hdr_crc[7:0], b};
            POS_LEN_HI, POS_LEN_LO: hdr_len    = {hdr_len[7:0], b};
            default: ;
         endcase
         // crc pair itself is not covered
         if (pos != POS_CRC_HI && pos != POS_CRC_LO) frm_crc = crc16_step(frm_crc, b);
         if (pos >= HDR_COUNT) begin
            words[n].kind         = KIND_PAYLOAD;
            words[n].payload_byte = b;
            n++;
         end
         if (frm_count >= HDR_COUNT && int'(frm_count) == HEADER_BYTES + int'(hdr_len)) begin
            words[n].kind           = (frm_crc == hdr_crc) ? KIND_ACCEPT : KIND_MISMATCH;
            words[n].msg_type       = hdr_type;
            words[n].msg_box        = hdr_box;
            words[n].frame_status   = hdr_status;
            words[n].payload_length = hdr_len[7:0];
            words[n].crc_received   = hdr_crc;
            n++;
            frm_open  = 1'b0;
            frm_count = '0;
         end
      end
      if (n > 0) words[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) frame_results.push_back(words[i]);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // ---------------- stimulus helpers ----------------
   // frame bytes with crc over all but the crc pair; body_cnt may exceed len
   task automatic build_frame(input logic [7:0] first_b, input logic [7:0] second_b,
                              input logic [7:0] msg_t, input logic [15:0] box,
                              input logic [7:0] status, input logic [15:0] len,
                              input int body_cnt, input bit bad_crc,
                              output byte_list_type frame);
      logic [15:0] crc;
      frame = {};
      frame.push_back(first_b);
      frame.push_back(second_b);
      frame.push_back(msg_t);
      frame.push_back(box[15:8]);
      frame.push_back(box[7:0]);
      frame.push_back(status);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      for (int i = 0; i < body_cnt; i++) frame.push_back(8'($urandom));
      crc = 16'h0000;
      foreach (frame[i]) if (i != 6 && i != 7) crc = crc16_step(crc, frame[i]);
      if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
      frame[6] = crc[15:8];
      frame[7] = crc[7:0];
   endtask

   task automatic offer(input byte_list_type f);
      foreach (f[i]) byte_backlog.push_back(f[i]);
   endtask

   // sender idle and every predicted word seen
   task automatic wait_drained();
      while (byte_backlog.size() != 0 || req_if.valid || frame_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync(input logic [7:0] value);
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.sync_byte <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      cur_sync = value;
   endtask

   // ---------------- request driver ----------------
   // bursts of random length with random gaps; valid holds until taken
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (byte_backlog.size() != 0) begin
            req_if.rx_byte <= byte_backlog.pop_front();
            req_if.valid   <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------- result receiver ----------------
   // stall rate changes per window; long hold-off on request
   int hold_left = 0;
   int mode_left = 0;
   int stall_pct = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_served < hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(4, 60);
               case ($urandom_range(0, 4))
                  0, 1:    stall_pct = 0;
                  2:       stall_pct = 25;
                  3:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            mode_left--;
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ---------------- monitor, model update, watchdog ----------------
   // check first, then predict: a word never leaves on the edge its byte enters
   always @(posedge clock) begin : monitor
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind           = kind_type'(rsp_if.kind);
            got.last           = rsp_if.last;
            got.payload_byte   = rsp_if.payload_byte;
            got.msg_type       = rsp_if.msg_type;
            got.msg_box        = rsp_if.msg_box;
            got.frame_status   = rsp_if.frame_status;
            got.payload_length = rsp_if.payload_length;
            got.crc_received   = rsp_if.crc_received;
            if (frame_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none actual kind %0d byte %0h",
                        $time, got.kind, got.payload_byte);
               error_count++;
            end else begin
               want = frame_results.pop_front();
               check_field("kind",           want.kind,           got.kind);
               check_field("last",           want.last,           got.last);
               check_field("payload_byte",   want.payload_byte,   got.payload_byte);
               check_field("msg_type",       want.msg_type,       got.msg_type);
               check_field("msg_box",        want.msg_box,        got.msg_box);
               check_field("frame_status",   want.frame_status,   got.frame_status);
               check_field("payload_length", want.payload_length, got.payload_length);
               check_field("crc_received",   want.crc_received,   got.crc_received);
            end
         end
         if (csr_if.valid && csr_if.ready) sync_model = csr_if.sync_byte;
         if (req_if.valid && req_if.ready) deframe_byte(req_if.rx_byte);

         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= LIMIT_CYCLES) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     frame_results.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------- test sequence ----------------
   initial begin : sequence_main
      byte_list_type frame;
      logic [7:0]    sync_plan [5];
      int            phase_items;
      int            pick;
      logic [7:0]    second_b;
      logic [7:0]    noise_b;
      logic [15:0]   len;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.rx_byte   = 8'h00;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.sync_byte = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset sync value
      byte_backlog.push_back(8'h00);          // idle noise, ignored
      byte_backlog.push_back(8'hFF);
      byte_backlog.push_back(SYNC_RESET);     // second byte not sync: dropped
      byte_backlog.push_back(8'h55);
      // empty payload: end word on the tenth byte
      build_frame(SYNC_RESET, SYNC_RESET, 8'h00, 16'h0000, 8'h00, 16'd0, 0, 1'b0, frame);
      offer(frame);
      // one payload byte: payload word and mismatch word from one byte
      build_frame(SYNC_RESET, SYNC_RESET, 8'hFF, 16'hFFFF, 8'hFF, 16'd1, 1, 1'b1, frame);
      offer(frame);
      wait_drained();

      // sync changed inside a frame: the new value applies to the second byte
      byte_backlog.push_back(SYNC_RESET);
      wait_drained();
      write_sync(8'h3C);
      byte_backlog.push_back(SYNC_RESET);     // stale sync as second byte: dropped
      byte_backlog.push_back(8'h3C);
      wait_drained();
      write_sync(8'hC3);
      build_frame(8'h3C, 8'hC3, 8'($urandom), 16'($urandom), 8'($urandom), 16'd3, 3, 1'b0,
                  frame);
      void'(frame.pop_front());
      offer(frame);
      wait_drained();

      // random phases, one sync setting each
      sync_plan = '{8'h00, 8'hFF, 8'h00, SYNC_RESET, 8'h00};
      sync_plan[2] = 8'($urandom);
      sync_plan[4] = 8'($urandom);
      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_sync(sync_plan[p]);
         phase_items = 0;
         if (p == 1) begin
            // longest legal frame while the sink holds off: input backs up
            build_frame(cur_sync, cur_sync, 8'($urandom), 16'($urandom), 8'($urandom),
                        16'(MAX_FRAME_BYTES - HEADER_BYTES), MAX_FRAME_BYTES - HEADER_BYTES,
                        1'b0, frame);
            offer(frame);
            hold_requests++;
            phase_items += frame.size();
         end
         if (p == 3) begin
            // too long: full buffer plus one byte gives the overflow word
            len = 16'($urandom_range(MAX_FRAME_BYTES - HEADER_BYTES + 1, 65535));
            build_frame(cur_sync, cur_sync, 8'($urandom), 16'($urandom), 8'($urandom),
                        len, MAX_FRAME_BYTES - HEADER_BYTES + 1, 1'b0, frame);
            offer(frame);
            phase_items += frame.size();
         end
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(17, 40))
                                                : 16'($urandom_range(0, 16));
               build_frame(cur_sync, cur_sync, 8'($urandom), 16'($urandom), 8'($urandom),
                           len, int'(len), ($urandom_range(0, 3) == 0), frame);
               offer(frame);
               phase_items += frame.size();
            end else if (pick < 90) begin
               do second_b = 8'($urandom); while (second_b == cur_sync);
               byte_backlog.push_back(cur_sync);
               byte_backlog.push_back(second_b);
               phase_items += 2;
            end else begin
               do noise_b = 8'($urandom); while (noise_b == cur_sync);
               byte_backlog.push_back(noise_b);
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/cfd_pkg.sv
hdl/cfd_ifs.sv
hdl/cfd_core.sv
hdl/cfd_rsp_queue.sv
hdl/command_frame_deframer_crc16_unit.sv
tb/tb_command_frame_deframer_crc16_unit.sv
